### sv/dtt_pkg.sv
package dtt_pkg;

  // Request codes
  localparam logic [2:0] F_ADD     = 3'd0;
  localparam logic [2:0] F_CANCEL  = 3'd1;
  localparam logic [2:0] F_REFRESH = 3'd2;
  localparam logic [2:0] F_RESET   = 3'd3;
  localparam logic [2:0] F_EXPIRE  = 3'd4;
  localparam logic [2:0] F_QUERY   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Most results one expire request may produce
  localparam int unsigned MAX_RESULTS = 16;
  // Slot index width carried along the chain (covers up to 256 slots)
  localparam int unsigned IDX_W = 8;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_ADD,
    CO_CANCEL,
    CO_DL,
    CO_PER_DL,
    CO_EXPIRE,
    CO_CLR_TAKEN
  } cell_op_e;

  typedef enum logic [1:0] {
    SC_FREE,
    SC_DUE,
    SC_ACTIVE,
    SC_OTHER
  } scan_e;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_e    op;
    logic [63:0] dl;
    logic [31:0] per;
    logic        rec;
  } cmd_t;

  // Running best candidate handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [63:0]      dl;
    logic [IDX_W-1:0] idx;
  } carry_t;

endpackage

### sv/dtt_cell.sv
module dtt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sel_i,
  input  dtt_pkg::cmd_t    cmd_i,
  input  dtt_pkg::scan_e   mode_i,
  input  logic [63:0]      now_i,
  input  dtt_pkg::carry_t  carry_i,
  output dtt_pkg::carry_t  carry_o,
  output logic [63:0]      dl_o,
  output logic [31:0]      per_o,
  output logic             act_o
);

  localparam int unsigned IDX_W = dtt_pkg::IDX_W;

  logic [63:0] dl_q;
  logic [31:0] per_q;
  logic        rec_q;
  logic        act_q;
  logic        taken_q;
  logic        cand;
  logic        take;
  dtt_pkg::carry_t carry_q;

  // Decide whether this slot beats the incoming best
  always_comb begin
    case (mode_i)
      dtt_pkg::SC_FREE:   cand = !act_q;
      dtt_pkg::SC_DUE:    cand = act_q && !taken_q && (dl_q <= now_i);
      dtt_pkg::SC_ACTIVE: cand = act_q;
      dtt_pkg::SC_OTHER:  cand = act_q && !sel_i;
      default:            cand = 1'b0;
    endcase
    if (mode_i == dtt_pkg::SC_FREE) begin
      take = cand && !carry_i.found;
    end else begin
      take = cand && (!carry_i.found || (dl_q < carry_i.dl));
    end
  end

  // Hand the best on to the next cell
  always_ff @(posedge clk_i) begin
    if (take) begin
      carry_q.found <= 1'b1;
      carry_q.dl    <= dl_q;
      carry_q.idx   <= IDX_W'(IDX);
    end else begin
      carry_q <= carry_i;
    end
  end

  // Apply slot updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q    <= '0;
      per_q   <= '0;
      rec_q   <= 1'b0;
      act_q   <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      if (cmd_i.op == dtt_pkg::CO_CLR_TAKEN) begin
        taken_q <= 1'b0;
      end else if (sel_i) begin
        case (cmd_i.op)
          dtt_pkg::CO_ADD: begin
            dl_q  <= cmd_i.dl;
            per_q <= cmd_i.per;
            rec_q <= cmd_i.rec;
            act_q <= 1'b1;
          end
          dtt_pkg::CO_CANCEL: act_q <= 1'b0;
          dtt_pkg::CO_DL:     dl_q  <= cmd_i.dl;
          dtt_pkg::CO_PER_DL: begin
            dl_q  <= cmd_i.dl;
            per_q <= cmd_i.per;
          end
          dtt_pkg::CO_EXPIRE: begin
            taken_q <= 1'b1;
            if (rec_q) begin
              dl_q <= cmd_i.dl;
            end else begin
              act_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign carry_o = carry_q;
  assign dl_o    = dl_q;
  assign per_o   = per_q;
  assign act_o   = act_q;

endmodule

### sv/deadline_timer_table.sv
// Deadline timer table: a row of timer slot cells, one request at a time.
// Request channel: the fields are taken at a rising edge with start high and
// busy low; busy stays high while the request is worked on and drops in the
// cycle that shows its last result, so the next request may be taken there.
// Result channel: res_valid_o marks each result for exactly one cycle; the
// receiver cannot stall it. last_o flags the final result of a request.
// Scans (free slot, earliest deadline, next due slot) run as a wave along the
// chain of NUM_SLOTS cells, one cell per cycle.
// Cancel, refresh and an unchanged or failed reset answer from the dispatch
// state; a query ends after an active scan; reset from now writes the slot
// and scans the others; reset from the old start writes the slot in its own
// state, then scans the others; add scans for a free slot, writes it and
// scans the others, or answers full after its first scan; expire scans once
// per due slot, up to 16, and once more to find none below that limit.
// Codes 6 and 7 give no result; they return from dispatch straight to idle.
// Reset clears all active marks and the pending notice; the block leaves
// reset idle, ready to accept a request.
module deadline_timer_table #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [63:0] now_ms_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] period_ms_i,
  input  logic        repeat_req_i,
  input  logic        from_now_i,
  output logic        res_valid_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_id_o,
  output logic [63:0] delay_ms_o,
  output logic        front_notice_o,
  output logic        last_o
);

  localparam int unsigned SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned RC_W  = $clog2(dtt_pkg::MAX_RESULTS + 1);
  localparam int unsigned IDX_W = dtt_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_ADD_WR, S_RST_WR, S_NOTE, S_EXP, S_EXP_LAST, S_QRY
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic [63:0] delay;
    logic        fn;
    logic        last;
  } res_t;

  state_e state_q, ret_q;
  dtt_pkg::scan_e mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RC_W-1:0]  rcnt_q;
  logic [2:0]  func_q;
  logic [63:0] now_q;
  logic [3:0]  slot_q;
  logic [31:0] per_q;
  logic        rep_q;
  logic        fnow_q;
  logic [63:0] tmp_q;
  logic [SW-1:0] tgt_q;
  logic [SW-1:0] pend_q;
  logic        pend_v_q;
  logic        np_q;
  logic        res_valid_q;
  res_t        res_q;

  dtt_pkg::cmd_t   cmd;
  dtt_pkg::carry_t chain [NUM_SLOTS+1];
  dtt_pkg::carry_t best;
  logic [63:0] dl_a  [NUM_SLOTS];
  logic [31:0] per_a [NUM_SLOTS];
  logic        act_a [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] sel;
  logic [SW-1:0] sel_idx;
  logic [SW-1:0] slot_idx;
  logic [63:0] rd_dl;
  logic [31:0] rd_per;
  logic        in_range;
  logic        slot_ok;
  logic [31:0] old_per;
  logic        same_per;
  logic [63:0] add_a, add_b, sum;
  logic        first;

  function automatic res_t mk(logic [1:0] st, logic [3:0] id, logic [63:0] dly,
                              logic fn, logic lst);
    res_t r;
    r.status  = st;
    r.slot_id = id;
    r.delay   = dly;
    r.fn      = fn;
    r.last    = lst;
    return r;
  endfunction

  // Row of slot cells, carry wave runs from cell 0 upward
  assign chain[0] = '0;
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    assign sel[k] = (sel_idx == SW'(k));
    dtt_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (sel[k]),
      .cmd_i   (cmd),
      .mode_i  (mode_q),
      .now_i   (now_q),
      .carry_i (chain[k]),
      .carry_o (chain[k+1]),
      .dl_o    (dl_a[k]),
      .per_o   (per_a[k]),
      .act_o   (act_a[k])
    );
  end
  assign best = chain[NUM_SLOTS];

  // Decode the addressed slot
  assign slot_idx = SW'(slot_q);
  assign in_range = {28'd0, slot_q} < 32'(NUM_SLOTS);
  assign rd_dl    = dl_a[sel_idx];
  assign rd_per   = per_a[sel_idx];
  assign slot_ok  = in_range && act_a[sel_idx];
  assign old_per  = in_range ? rd_per : 32'd0;
  assign same_per = (per_q == old_per) && !fnow_q;
  assign sum      = add_a + add_b;
  assign first    = !best.found || (rd_dl < best.dl) ||
                    ((rd_dl == best.dl) && (IDX_W'(tgt_q) < best.idx));

  // Build the cell command and the shared adder operands
  always_comb begin
    cmd.op  = dtt_pkg::CO_NONE;
    cmd.dl  = sum;
    cmd.per = per_q;
    cmd.rec = rep_q;
    sel_idx = slot_idx;
    add_a   = now_q;
    add_b   = {32'd0, rd_per};
    case (state_q)
      S_DISP: begin
        case (func_q)
          dtt_pkg::F_CANCEL: if (slot_ok) cmd.op = dtt_pkg::CO_CANCEL;
          dtt_pkg::F_REFRESH: if (slot_ok) cmd.op = dtt_pkg::CO_DL;
          dtt_pkg::F_RESET: begin
            add_b = {32'd0, per_q};
            if (!same_per && slot_ok && fnow_q) cmd.op = dtt_pkg::CO_PER_DL;
          end
          dtt_pkg::F_EXPIRE: cmd.op = dtt_pkg::CO_CLR_TAKEN;
          default: ;
        endcase
      end
      S_ADD_WR: begin
        sel_idx = SW'(best.idx);
        add_b   = {32'd0, per_q};
        if (best.found) cmd.op = dtt_pkg::CO_ADD;
      end
      S_RST_WR: begin
        add_a  = tmp_q;
        add_b  = {32'd0, per_q};
        cmd.op = dtt_pkg::CO_PER_DL;
      end
      S_SCAN, S_NOTE: sel_idx = tgt_q;
      S_EXP: begin
        sel_idx = SW'(best.idx);
        if (best.found) cmd.op = dtt_pkg::CO_EXPIRE;
      end
      default: ;
    endcase
  end

  // Sequence requests, hold results for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      mode_q      <= dtt_pkg::SC_FREE;
      cnt_q       <= '0;
      rcnt_q      <= '0;
      func_q      <= '0;
      now_q       <= '0;
      slot_q      <= '0;
      per_q       <= '0;
      rep_q       <= 1'b0;
      fnow_q      <= 1'b0;
      tmp_q       <= '0;
      tgt_q       <= '0;
      pend_q      <= '0;
      pend_v_q    <= 1'b0;
      np_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            func_q  <= func_i;
            now_q   <= now_ms_i;
            slot_q  <= slot_i;
            per_q   <= period_ms_i;
            rep_q   <= repeat_req_i;
            fnow_q  <= from_now_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          state_q <= S_IDLE;
          cnt_q   <= '0;
          case (func_q)
            dtt_pkg::F_ADD: begin
              mode_q  <= dtt_pkg::SC_FREE;
              ret_q   <= S_ADD_WR;
              state_q <= S_SCAN;
            end
            dtt_pkg::F_CANCEL, dtt_pkg::F_REFRESH: begin
              res_valid_q <= 1'b1;
              res_q <= mk(slot_ok ? dtt_pkg::ST_OK : dtt_pkg::ST_INACTIVE,
                          slot_q, 64'd0, 1'b0, 1'b1);
            end
            dtt_pkg::F_RESET: begin
              if (same_per || !slot_ok) begin
                res_valid_q <= 1'b1;
                res_q <= mk(same_per ? dtt_pkg::ST_OK : dtt_pkg::ST_INACTIVE,
                            slot_q, 64'd0, 1'b0, 1'b1);
              end else if (fnow_q) begin
                tgt_q   <= slot_idx;
                mode_q  <= dtt_pkg::SC_OTHER;
                ret_q   <= S_NOTE;
                state_q <= S_SCAN;
              end else begin
                tmp_q   <= rd_dl - {32'd0, old_per};
                state_q <= S_RST_WR;
              end
            end
            dtt_pkg::F_EXPIRE: begin
              rcnt_q   <= '0;
              pend_v_q <= 1'b0;
              mode_q   <= dtt_pkg::SC_DUE;
              ret_q    <= S_EXP;
              state_q  <= S_SCAN;
            end
            dtt_pkg::F_QUERY: begin
              np_q    <= 1'b0;
              mode_q  <= dtt_pkg::SC_ACTIVE;
              ret_q   <= S_QRY;
              state_q <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NUM_SLOTS - 1)) state_q <= ret_q;
        end
        S_ADD_WR: begin
          cnt_q <= '0;
          if (!best.found) begin
            res_valid_q <= 1'b1;
            res_q   <= mk(dtt_pkg::ST_FULL, 4'd0, 64'd0, 1'b0, 1'b1);
            state_q <= S_IDLE;
          end else begin
            tgt_q   <= SW'(best.idx);
            mode_q  <= dtt_pkg::SC_OTHER;
            ret_q   <= S_NOTE;
            state_q <= S_SCAN;
          end
        end
        S_RST_WR: begin
          cnt_q   <= '0;
          tgt_q   <= slot_idx;
          mode_q  <= dtt_pkg::SC_OTHER;
          ret_q   <= S_NOTE;
          state_q <= S_SCAN;
        end
        S_NOTE: begin
          res_valid_q <= 1'b1;
          res_q   <= mk(dtt_pkg::ST_OK, 4'(tgt_q), 64'd0, first && !np_q, 1'b1);
          if (first) np_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_EXP: begin
          cnt_q <= '0;
          if (best.found) begin
            if (pend_v_q) begin
              res_valid_q <= 1'b1;
              res_q <= mk(dtt_pkg::ST_OK, 4'(pend_q), 64'd0, 1'b0, 1'b0);
            end
            pend_q   <= SW'(best.idx);
            pend_v_q <= 1'b1;
            rcnt_q   <= rcnt_q + 1'b1;
            if (rcnt_q == RC_W'(dtt_pkg::MAX_RESULTS - 1)) begin
              state_q <= S_EXP_LAST;
            end else begin
              state_q <= S_SCAN;
            end
          end else begin
            res_valid_q <= 1'b1;
            res_q <= pend_v_q ? mk(dtt_pkg::ST_OK, 4'(pend_q), 64'd0, 1'b0, 1'b1)
                              : mk(dtt_pkg::ST_NONE, 4'd0, 64'd0, 1'b0, 1'b1);
            state_q <= S_IDLE;
          end
        end
        S_EXP_LAST: begin
          res_valid_q <= 1'b1;
          res_q   <= mk(dtt_pkg::ST_OK, 4'(pend_q), 64'd0, 1'b0, 1'b1);
          state_q <= S_IDLE;
        end
        S_QRY: begin
          res_valid_q <= 1'b1;
          if (!best.found) begin
            res_q <= mk(dtt_pkg::ST_OK, 4'd0, '1, 1'b0, 1'b1);
          end else if (best.dl <= now_q) begin
            res_q <= mk(dtt_pkg::ST_OK, 4'd0, 64'd0, 1'b0, 1'b1);
          end else begin
            res_q <= mk(dtt_pkg::ST_OK, 4'd0, best.dl - now_q, 1'b0, 1'b1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign res_valid_o    = res_valid_q;
  assign status_o       = res_q.status;
  assign slot_id_o      = res_q.slot_id;
  assign delay_ms_o     = res_q.delay;
  assign front_notice_o = res_q.fn;
  assign last_o         = res_q.last;

  // A result is only shown after work that was in progress
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy)) else $error("result without request");

  // An accepted request makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");

  // A raised notice leaves the pending mark set
  a_notice_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && front_notice_o) |-> np_q) else $error("notice not recorded");

  // Expire never produces more than the result limit
  a_rcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RC_W'(dtt_pkg::MAX_RESULTS)) else $error("too many expire results");

endmodule
